### hw/rtl/chained_hash_set_defines.svh
// Assertion macros for the chained hash set.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef CHAINED_HASH_SET_DEFINES_SVH
`define CHAINED_HASH_SET_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CHS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("chained_hash_set: check failed");
`define CHS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("chained_hash_set: sequence check failed");
`else
`define CHS_ASSERT(lbl, prop)
`define CHS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/chs_pkg.sv
// Shared types and constants of the chained hash set.
// No dependencies.
package chs_pkg;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_SEARCH = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_LOST = 2'd2;

   localparam logic       CSR_INITIAL_BUCKETS = 1'b0;
   localparam logic       CSR_LOAD_THRESHOLD  = 1'b1;

   localparam logic [31:0] HASH_MULT = 32'd2654435769;
   localparam int          KEY_W     = 32;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### hw/rtl/chained_hash_set.sv
// Chained hash set of 32-bit keys: top level with sequencer, key store and fill tables.
// Depends on chs_pkg, chs_divider and chained_hash_set_defines.svh.
// One item at a time; req_stall is high from acceptance until the result is registered.
// Every bucket index and the load figure come from one shared 32-step divider. A search ends
// early when it hits. An insert that doubles the bucket count (capped at MAX_BUCKETS) first
// rehashes every stored key through the divider, bucket by bucket, into the other bank and
// then swaps banks.
// Unknown request codes answer with all-zero fields, with no hash or table access.
module chained_hash_set #(
   parameter int MAX_BUCKETS      = 64,
   parameter int SLOTS_PER_BUCKET = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [1:0]  rsp_status,
   output logic        rsp_grew,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import chs_pkg::*;
`include "chained_hash_set_defines.svh"

   localparam int NBW    = $clog2(MAX_BUCKETS + 1);
   localparam int BW     = $clog2(MAX_BUCKETS);
   localparam int FW     = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int CW     = $clog2(MAX_BUCKETS * SLOTS_PER_BUCKET + 1);
   localparam int DEPTH  = 2 * MAX_BUCKETS * SLOTS_PER_BUCKET;
   localparam int AW     = $clog2(DEPTH);
   localparam int FDEPTH = 2 * MAX_BUCKETS;
   localparam int FAW    = $clog2(FDEPTH);
   localparam int NB_RST = (16 > MAX_BUCKETS) ? MAX_BUCKETS : 16;

   typedef enum logic [21:0] {
      S_IDLE    = 22'h000001,
      S_LSTART  = 22'h000002,
      S_LWAIT   = 22'h000004,
      S_GFRD    = 22'h000008,
      S_GFWAIT  = 22'h000010,
      S_GCHK    = 22'h000020,
      S_GKRD    = 22'h000040,
      S_GKWAIT  = 22'h000080,
      S_GHASH   = 22'h000100,
      S_GHSTART = 22'h000200,
      S_GHWAIT  = 22'h000400,
      S_GDRD    = 22'h000800,
      S_GDWAIT  = 22'h001000,
      S_GEND    = 22'h002000,
      S_HASH    = 22'h004000,
      S_HSTART  = 22'h008000,
      S_HWAIT   = 22'h010000,
      S_FRD     = 22'h020000,
      S_FWAIT   = 22'h040000,
      S_SRD     = 22'h080000,
      S_SCMP    = 22'h100000,
      S_DONE    = 22'h200000
   } state_type;

   function automatic logic [AW-1:0] slot_addr(input logic bk, input logic [BW-1:0] b,
                                                input logic [FW-1:0] s);
      slot_addr = AW'(bk) * AW'(MAX_BUCKETS * SLOTS_PER_BUCKET)
                + AW'(b) * AW'(SLOTS_PER_BUCKET) + AW'(s);
   endfunction

   function automatic logic [FAW-1:0] fill_addr(input logic bk, input logic [BW-1:0] b);
      fill_addr = FAW'(bk) * FAW'(MAX_BUCKETS) + FAW'(b);
   endfunction

   state_type st_ff, st_in;

   logic [1:0]    type_ff, type_in;
   logic [31:0]   key_ff, key_in;
   logic          found_ff, found_in;
   logic [1:0]    status_ff, status_in;
   logic          grew_ff, grew_in;
   logic [NBW-1:0] nb_ff, nb_in;
   logic [NBW-1:0] nbnew_ff, nbnew_in;
   logic [7:0]    thr_ff, thr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          bank_ff, bank_in;
   logic [BW-1:0] gb_ff, gb_in;
   logic [FW-1:0] gs_ff, gs_in;
   logic [FW-1:0] gfill_ff, gfill_in;
   logic [31:0]   gkey_ff, gkey_in;
   logic [31:0]   hash_ff, hash_in;
   logic [BW-1:0] bucket_ff, bucket_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] s_ff, s_in;
   logic [FW-1:0] n_ff, n_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_status_unused;
   logic [1:0]    rsp_status_ff;
   logic          rsp_grew_ff;

   logic [31:0]   slot_mem [DEPTH];
   logic [31:0]   slot_rd_ff;
   logic [AW-1:0] slot_raddr, slot_waddr;
   logic [31:0]   slot_wdata;
   logic          slot_we;

   logic [FW-1:0]  fill_mem [FDEPTH];
   logic [FW-1:0]  fill_rd_ff;
   logic           fill_rvld_ff;
   logic [FDEPTH-1:0] vld_ff, vld_in;
   logic [FAW-1:0] fill_raddr, fill_waddr;
   logic [FW-1:0]  fill_wdata;
   logic           fill_we;
   logic [FW-1:0]  fill_eff;

   logic              div_start;
   logic [31:0]       div_dividend;
   logic [NBW-1:0]    div_divisor;
   div_stat_type      div_stat;
   logic [31:0]       div_quo;
   logic [NBW-1:0]    div_rem;
   logic [31:0]       load;
   logic [NBW:0]      dbl;
   logic [NBW-1:0]    cfg_nb;

   chs_divider #(.VW(NBW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign fill_eff = fill_rvld_ff ? fill_rd_ff : '0;
   assign rsp_status_unused = 1'b0;

   always_comb begin
      div_start    = (st_ff == S_LSTART) || (st_ff == S_HSTART) || (st_ff == S_GHSTART);
      div_dividend = (st_ff == S_LSTART) ? 32'(count_ff) : hash_ff;
      div_divisor  = (st_ff == S_GHSTART) ? nbnew_ff : nb_ff;
      load = 32'(div_quo[CW-1:0]) * 32'(SLOTS_PER_BUCKET);
      dbl  = {nb_ff, 1'b0};
      if (csr_wdata[6:0] == 7'd0) begin
         cfg_nb = NBW'(1);
      end else if (32'(csr_wdata[6:0]) > 32'(MAX_BUCKETS)) begin
         cfg_nb = NBW'(MAX_BUCKETS);
      end else begin
         cfg_nb = NBW'(csr_wdata[6:0]);
      end
   end

   always_comb begin
      st_in = st_ff;
      type_in = type_ff;
      key_in = key_ff;
      found_in = found_ff;
      status_in = status_ff;
      grew_in = grew_ff;
      nb_in = nb_ff;
      nbnew_in = nbnew_ff;
      thr_in = thr_ff;
      count_in = count_ff;
      bank_in = bank_ff;
      gb_in = gb_ff;
      gs_in = gs_ff;
      gfill_in = gfill_ff;
      gkey_in = gkey_ff;
      hash_in = hash_ff;
      bucket_in = bucket_ff;
      fill_in = fill_ff;
      s_in = s_ff;
      n_in = n_ff;
      vld_in = vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      slot_raddr = '0;
      slot_we = 1'b0;
      slot_waddr = '0;
      slot_wdata = '0;
      fill_raddr = '0;
      fill_we = 1'b0;
      fill_waddr = '0;
      fill_wdata = '0;

      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               type_in = req_type;
               key_in = req_key;
               found_in = 1'b0;
               status_in = STAT_OK;
               grew_in = 1'b0;
               if (req_type == REQ_INSERT) begin
                  st_in = S_LSTART;
               end else if (req_type == REQ_SEARCH || req_type == REQ_DELETE) begin
                  st_in = S_HASH;
               end else begin
                  st_in = S_DONE;
               end
            end
         end
         S_LSTART: st_in = S_LWAIT;
         S_LWAIT: begin
            if (div_stat.done) begin
               if (load > 32'(thr_ff) && 32'(nb_ff) < 32'(MAX_BUCKETS)) begin
                  nbnew_in = (32'(dbl) > 32'(MAX_BUCKETS)) ? NBW'(MAX_BUCKETS)
                                                          : dbl[NBW-1:0];
                  grew_in = 1'b1;
                  gb_in = '0;
                  for (int i = 0; i < FDEPTH; i++) begin
                     if ((i >= MAX_BUCKETS) != bank_ff) begin
                        vld_in[i] = 1'b0;
                     end
                  end
                  st_in = S_GFRD;
               end else begin
                  st_in = S_HASH;
               end
            end
         end
         S_GFRD: begin
            fill_raddr = fill_addr(bank_ff, gb_ff);
            st_in = S_GFWAIT;
         end
         S_GFWAIT: begin
            gfill_in = fill_eff;
            gs_in = '0;
            st_in = S_GCHK;
         end
         S_GCHK: begin
            if (gs_ff < gfill_ff) begin
               st_in = S_GKRD;
            end else if (32'(gb_ff) + 32'd1 == 32'(nb_ff)) begin
               st_in = S_GEND;
            end else begin
               gb_in = gb_ff + 1'b1;
               st_in = S_GFRD;
            end
         end
         S_GKRD: begin
            slot_raddr = slot_addr(bank_ff, gb_ff, gs_ff);
            st_in = S_GKWAIT;
         end
         S_GKWAIT: begin
            gkey_in = slot_rd_ff;
            st_in = S_GHASH;
         end
         S_GHASH: begin
            hash_in = gkey_ff * HASH_MULT;
            st_in = S_GHSTART;
         end
         S_GHSTART: st_in = S_GHWAIT;
         S_GHWAIT: begin
            if (div_stat.done) begin
               bucket_in = div_rem[BW-1:0];
               st_in = S_GDRD;
            end
         end
         S_GDRD: begin
            fill_raddr = fill_addr(!bank_ff, bucket_ff);
            st_in = S_GDWAIT;
         end
         S_GDWAIT: begin
            if (32'(fill_eff) < 32'(SLOTS_PER_BUCKET)) begin
               slot_we = 1'b1;
               slot_waddr = slot_addr(!bank_ff, bucket_ff, fill_eff);
               slot_wdata = gkey_ff;
               fill_we = 1'b1;
               fill_waddr = fill_addr(!bank_ff, bucket_ff);
               fill_wdata = fill_eff + 1'b1;
            end else begin
               status_in = STAT_LOST;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end
            gs_in = gs_ff + 1'b1;
            st_in = S_GCHK;
         end
         S_GEND: begin
            bank_in = !bank_ff;
            nb_in = nbnew_ff;
            st_in = S_HASH;
         end
         S_HASH: begin
            hash_in = key_ff * HASH_MULT;
            st_in = S_HSTART;
         end
         S_HSTART: st_in = S_HWAIT;
         S_HWAIT: begin
            if (div_stat.done) begin
               bucket_in = div_rem[BW-1:0];
               st_in = S_FRD;
            end
         end
         S_FRD: begin
            fill_raddr = fill_addr(bank_ff, bucket_ff);
            st_in = S_FWAIT;
         end
         S_FWAIT: begin
            fill_in = fill_eff;
            s_in = '0;
            n_in = '0;
            if (type_ff == REQ_INSERT) begin
               if (32'(fill_eff) < 32'(SLOTS_PER_BUCKET)) begin
                  slot_we = 1'b1;
                  slot_waddr = slot_addr(bank_ff, bucket_ff, fill_eff);
                  slot_wdata = key_ff;
                  fill_we = 1'b1;
                  fill_waddr = fill_addr(bank_ff, bucket_ff);
                  fill_wdata = fill_eff + 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  status_in = STAT_FULL;
               end
               st_in = S_DONE;
            end else begin
               st_in = S_SRD;
            end
         end
         S_SRD: begin
            if (s_ff < fill_ff) begin
               slot_raddr = slot_addr(bank_ff, bucket_ff, s_ff);
               st_in = S_SCMP;
            end else begin
               if (type_ff == REQ_DELETE) begin
                  fill_we = 1'b1;
                  fill_waddr = fill_addr(bank_ff, bucket_ff);
                  fill_wdata = n_ff;
               end
               st_in = S_DONE;
            end
         end
         S_SCMP: begin
            s_in = s_ff + 1'b1;
            st_in = S_SRD;
            if (slot_rd_ff == key_ff) begin
               found_in = 1'b1;
               if (type_ff == REQ_SEARCH) begin
                  st_in = S_DONE;
               end else if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end else if (type_ff == REQ_DELETE) begin
               slot_we = 1'b1;
               slot_waddr = slot_addr(bank_ff, bucket_ff, n_ff);
               slot_wdata = slot_rd_ff;
               n_in = n_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase

      if (fill_we) begin
         vld_in[fill_waddr] = 1'b1;
      end

      if (csr_we) begin
         if (csr_index == CSR_INITIAL_BUCKETS) begin
            vld_in = '0;
            count_in = '0;
            nb_in = cfg_nb;
         end else begin
            thr_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[slot_raddr];
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_rd_ff <= fill_mem[fill_raddr];
      fill_rvld_ff <= vld_ff[fill_raddr];
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      key_ff <= key_in;
      found_ff <= found_in;
      status_ff <= status_in;
      grew_ff <= grew_in;
      nbnew_ff <= nbnew_in;
      gb_ff <= gb_in;
      gs_ff <= gs_in;
      gfill_ff <= gfill_in;
      gkey_ff <= gkey_in;
      hash_ff <= hash_in;
      bucket_ff <= bucket_in;
      fill_ff <= fill_in;
      s_ff <= s_in;
      n_ff <= n_in;
      if (st_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_found_ff <= found_ff;
         rsp_status_ff <= status_ff;
         rsp_grew_ff <= grew_ff;
      end
      if (reset) begin
         st_ff <= S_IDLE;
         nb_ff <= NBW'(NB_RST);
         thr_ff <= 8'd4;
         count_ff <= '0;
         bank_ff <= 1'b0;
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         nb_ff <= nb_in;
         thr_ff <= thr_in;
         count_ff <= count_in;
         bank_ff <= bank_in;
         vld_ff <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall  = (st_ff != S_IDLE) || rsp_status_unused;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_grew   = rsp_grew_ff;

   `CHS_ASSERT(a_nb_range, (nb_ff != '0) && (32'(nb_ff) <= 32'(MAX_BUCKETS)))
   `CHS_ASSERT(a_count_max, 32'(count_ff) <= 32'(MAX_BUCKETS * SLOTS_PER_BUCKET))
   `CHS_ASSERT(a_div_owner, div_stat.busy |-> (st_ff == S_LWAIT || st_ff == S_HWAIT || st_ff == S_GHWAIT))
   `CHS_ASSERT_NEXT(a_bank_swap, st_ff == S_GEND, (st_ff == S_HASH) && (bank_ff != $past(bank_ff)))

endmodule

### hw/rtl/chs_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on chs_pkg.
module chs_divider #(
   parameter int VW = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [chs_pkg::KEY_W-1:0] dividend,
   input  logic [VW-1:0]            divisor,
   output chs_pkg::div_stat_type    stat,
   output logic [chs_pkg::KEY_W-1:0] quotient,
   output logic [VW-1:0]            remainder
);
   import chs_pkg::*;

   localparam int CNTW = $clog2(KEY_W + 1);

   logic [KEY_W-1:0] quo_ff, quo_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    dvs_ff;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [VW:0]      trial;
   logic [VW:0]      diff;
   logic             qbit;

   always_comb begin
      trial  = {rem_ff, quo_ff[KEY_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      qbit   = (trial >= {1'b0, dvs_ff});
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNTW'(KEY_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[KEY_W-2:0], qbit};
         rem_in = qbit ? diff[VW-1:0] : trial[VW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
